/* src/mpsa_pkg.sv */
// Shared types, widths and register codes for the mirror-pad source address unit.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package mpsa_pkg;

    // tensor geometry
    localparam int NUM_DIMS     = 4;
    localparam int MAX_RANK     = 4;
    localparam int MAX_EXTENT   = 4096;
    localparam int FIRST_ACTIVE = NUM_DIMS - ((MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS);

    // field widths
    localparam int SETUP_W = 37;
    localparam int EXT_W   = 13;
    localparam int PAD_W   = 12;
    localparam int COORD_W = 14;
    localparam int SRC_W   = 12;
    localparam int OFF_W   = 48;
    localparam int IDX_W   = 3;

    // largest extent the 13-bit field and the size limit both allow
    localparam int EXT_CAP = (MAX_EXTENT < (2 ** EXT_W) - 1) ? MAX_EXTENT : (2 ** EXT_W) - 1;

    // internal arithmetic widths
    localparam int SUM_W = EXT_W + 2;     // extent + pre + post
    localparam int J_W   = COORD_W + 2;   // signed coordinate minus pre pad
    localparam int M_W   = J_W + 1;       // signed mirrored coordinate before clamp

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_DIM0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_DIM1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_DIM2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_DIM3 = 3'd3;
    localparam logic [IDX_W-1:0] REG_MODE = 3'd4;

    // pad modes
    localparam logic REFLECT   = 1'b0;
    localparam logic SYMMETRIC = 1'b1;

    localparam logic [SETUP_W-1:0] SETUP_RESET = SETUP_W'(1);

    // input transfer payload
    typedef struct packed {
        logic [COORD_W-1:0] out_coord0;
        logic [COORD_W-1:0] out_coord1;
        logic [COORD_W-1:0] out_coord2;
        logic [COORD_W-1:0] out_coord3;
    } t_in_item;

    // output transfer payload
    typedef struct packed {
        logic [SRC_W-1:0] src_coord0;
        logic [SRC_W-1:0] src_coord1;
        logic [SRC_W-1:0] src_coord2;
        logic [SRC_W-1:0] src_coord3;
        logic [OFF_W-1:0] source_offset;
        logic             range_error;
        logic             pad_error;
    } t_out_item;

    // decoded setup of one dimension
    typedef struct packed {
        logic [EXT_W-1:0] ext;
        logic [PAD_W-1:0] pre;
        logic [PAD_W-1:0] post;
    } t_dim_cfg;

    // decoded configuration seen by the datapath
    typedef struct packed {
        t_dim_cfg [NUM_DIMS-1:0] dims;
        logic                    mode;
    } t_cfg;

    // mirrored coordinates and flags between mirror and offset stages
    typedef struct packed {
        logic [NUM_DIMS-1:0][EXT_W-1:0] src;
        logic                           range_err;
        logic                           pad_err;
    } t_mid;

endpackage

/* src/mpsa_cfg.sv */
// Configuration registers and per-dimension setup decode (extent clamp, unused dims).
// Depends on mpsa_pkg.
`timescale 1ns / 1ps

module mpsa_cfg
    import mpsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [SETUP_W-1:0] i_cfg_data,
    output t_cfg               o_cfg
);

    logic [SETUP_W-1:0] r_setup [NUM_DIMS];
    logic               r_mode;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    // register file, index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NUM_DIMS; d++) begin
                r_setup[d] <= SETUP_RESET;
            end
            r_mode <= REFLECT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DIM0: r_setup[0] <= i_cfg_data;
                REG_DIM1: r_setup[1] <= i_cfg_data;
                REG_DIM2: r_setup[2] <= i_cfg_data;
                REG_DIM3: r_setup[3] <= i_cfg_data;
                REG_MODE: r_mode     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // decode extent and pads; dims above the rank act as extent 1, no pad
    always_comb begin : p_decode
        logic [EXT_W-1:0] ext_field;
        o_cfg      = '0;
        o_cfg.mode = r_mode;
        for (int d = 0; d < NUM_DIMS; d++) begin
            ext_field = r_setup[d][EXT_W-1:0];
            if (d < FIRST_ACTIVE) begin
                o_cfg.dims[d].ext  = EXT_W'(1);
                o_cfg.dims[d].pre  = '0;
                o_cfg.dims[d].post = '0;
            end else begin
                if (ext_field == '0) begin
                    o_cfg.dims[d].ext = EXT_W'(1);
                end else if (ext_field > EXT_W'(EXT_CAP)) begin
                    o_cfg.dims[d].ext = EXT_W'(EXT_CAP);
                end else begin
                    o_cfg.dims[d].ext = ext_field;
                end
                o_cfg.dims[d].pre  = r_setup[d][EXT_W +: PAD_W];
                o_cfg.dims[d].post = r_setup[d][EXT_W + PAD_W +: PAD_W];
            end
        end
    end

endmodule

/* src/mpsa_mirror.sv */
// Two pipeline stages: pre-pad subtract with range and pad checks, then mirror and clamp.
// Depends on mpsa_pkg; configuration comes decoded from mpsa_cfg.
`timescale 1ns / 1ps

module mpsa_mirror
    import mpsa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_mid     o_mid,
    output logic     o_full
);

    localparam logic signed [M_W-1:0] M_TWO = M_W'(2);

    logic [NUM_DIMS-1:0][COORD_W-1:0] w_coord;
    logic [NUM_DIMS-1:0][J_W-1:0]     w_j;
    logic [NUM_DIMS-1:0]              w_rng;
    logic [NUM_DIMS-1:0]              w_pad;
    logic [NUM_DIMS-1:0][EXT_W-1:0]   w_src;
    logic                             w_a_rdy;
    logic                             w_b_rdy;

    logic                             r_a_vld;
    logic [NUM_DIMS-1:0][J_W-1:0]     r_a_j;
    logic                             r_a_rng;
    logic                             r_a_pad;
    logic                             r_b_vld;
    logic [NUM_DIMS-1:0][EXT_W-1:0]   r_b_src;
    logic                             r_b_rng;
    logic                             r_b_pad;

    assign w_coord[0] = i_item.out_coord0;
    assign w_coord[1] = i_item.out_coord1;
    assign w_coord[2] = i_item.out_coord2;
    assign w_coord[3] = i_item.out_coord3;

    // ready chain, a bubble lets upstream move
    assign w_b_rdy = !r_b_vld || i_ready;
    assign w_a_rdy = !r_a_vld || w_b_rdy;
    assign o_ready = w_a_rdy;
    assign o_full  = r_a_vld && r_b_vld;

    // stage a: j = coord - pre, padded-extent check, pad limit check
    always_comb begin : p_stage_a
        logic [COORD_W-1:0] coord;
        logic [SUM_W-1:0]   limit;
        logic [EXT_W:0]     pad_max;
        for (int d = 0; d < NUM_DIMS; d++) begin
            coord    = (d < FIRST_ACTIVE) ? '0 : w_coord[d];
            limit    = {2'b00, i_cfg.dims[d].ext} + {3'b000, i_cfg.dims[d].pre}
                     + {3'b000, i_cfg.dims[d].post};
            w_rng[d] = {1'b0, coord} >= limit;
            w_j[d]   = {2'b00, coord} - {4'b0000, i_cfg.dims[d].pre};
            pad_max  = {1'b0, i_cfg.dims[d].ext} + {{EXT_W{1'b0}}, i_cfg.mode};
            w_pad[d] = ({2'b00, i_cfg.dims[d].pre} >= pad_max)
                    || ({2'b00, i_cfg.dims[d].post} >= pad_max);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_a_rdy) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_rdy && i_valid) begin
            r_a_j   <= w_j;
            r_a_rng <= |w_rng;
            r_a_pad <= |w_pad;
        end
    end

    // stage b: fold j back into the tensor, then clamp to 0..extent-1
    always_comb begin : p_stage_b
        logic signed [M_W-1:0] jx;
        logic signed [M_W-1:0] ex;
        logic signed [M_W-1:0] sy;
        logic signed [M_W-1:0] m;
        for (int d = 0; d < NUM_DIMS; d++) begin
            jx = signed'({r_a_j[d][J_W-1], r_a_j[d]});
            ex = signed'({{(M_W-EXT_W){1'b0}}, i_cfg.dims[d].ext});
            sy = signed'({{(M_W-1){1'b0}}, i_cfg.mode});
            if (jx < 0) begin
                m = -jx - sy;
            end else if (jx >= ex) begin
                m = ex + ex - M_TWO + sy - jx;
            end else begin
                m = jx;
            end
            if (m < 0) begin
                w_src[d] = '0;
            end else if (m >= ex) begin
                w_src[d] = i_cfg.dims[d].ext - EXT_W'(1);
            end else begin
                w_src[d] = m[EXT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_b_rdy) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_rdy && r_a_vld) begin
            r_b_src <= w_src;
            r_b_rng <= r_a_rng;
            r_b_pad <= r_a_pad;
        end
    end

    assign o_valid         = r_b_vld;
    assign o_mid.src       = r_b_src;
    assign o_mid.range_err = r_b_rng;
    assign o_mid.pad_err   = r_b_pad;

    // clamped source always lands inside the extent
    for (genvar g = 0; g < NUM_DIMS; g++) begin : g_chk
        a_src_in_extent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_b_vld |-> (r_b_src[g] < i_cfg.dims[g].ext))
            else $error("mirrored coordinate outside extent");
    end

    // a held stage a keeps its item
    a_stage_a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_vld && !w_b_rdy) |=> (r_a_vld && $stable(r_a_j)))
        else $error("stage a lost its item during a stall");

endmodule

/* src/mpsa_offset.sv */
// Row-major offset chain: one multiply-add per stage, offset = offset * extent + src.
// Depends on mpsa_pkg; takes mirrored coordinates from mpsa_mirror.
`timescale 1ns / 1ps

module mpsa_offset
    import mpsa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_mid      i_mid,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item,
    output logic      o_full
);

    localparam int NST = NUM_DIMS - 1;

    logic [NST-1:0]            w_rdy;
    logic [NST-1:0]            w_in_vld;
    logic [NST-1:0][OFF_W-1:0] w_acc;
    t_mid                      w_mid_in [NST];

    logic [NST-1:0]            r_vld;
    logic [NST-1:0][OFF_W-1:0] r_acc;
    t_mid                      r_mid [NST];

    // ready chain from the output back to the input
    always_comb begin
        w_rdy[NST-1] = !r_vld[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_full  = &r_vld;

    // multiply-add of each stage, first stage starts from the outermost source
    always_comb begin : p_mac
        logic [OFF_W-1:0]       acc_in;
        logic [OFF_W+EXT_W-1:0] prod;
        for (int k = 0; k < NST; k++) begin
            if (k == 0) begin
                acc_in      = {{(OFF_W-EXT_W){1'b0}}, i_mid.src[0]};
                w_mid_in[k] = i_mid;
                w_in_vld[k] = i_valid;
            end else begin
                acc_in      = r_acc[k-1];
                w_mid_in[k] = r_mid[k-1];
                w_in_vld[k] = r_vld[k-1];
            end
            prod     = {{EXT_W{1'b0}}, acc_in} * {{OFF_W{1'b0}}, i_cfg.dims[k+1].ext};
            w_acc[k] = prod[OFF_W-1:0] + {{(OFF_W-EXT_W){1'b0}}, w_mid_in[k].src[k+1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_in_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (w_rdy[k] && w_in_vld[k]) begin
                r_acc[k] <= w_acc[k];
                r_mid[k] <= w_mid_in[k];
            end
        end
    end

    // result register is the last stage
    assign o_valid              = r_vld[NST-1];
    assign o_item.src_coord0    = r_mid[NST-1].src[0][SRC_W-1:0];
    assign o_item.src_coord1    = r_mid[NST-1].src[1][SRC_W-1:0];
    assign o_item.src_coord2    = r_mid[NST-1].src[2][SRC_W-1:0];
    assign o_item.src_coord3    = r_mid[NST-1].src[3][SRC_W-1:0];
    assign o_item.source_offset = r_acc[NST-1];
    assign o_item.range_error   = r_mid[NST-1].range_err;
    assign o_item.pad_error     = r_mid[NST-1].pad_err;

    // first partial offset stays below the product of the two outer extents
    a_first_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_acc[0] < (i_cfg.dims[0].ext * i_cfg.dims[1].ext)))
        else $error("partial offset exceeds outer extents");

endmodule

/* src/mirror_pad_source_address_unit.sv */
// Top level of the mirror-pad source address unit: config registers, mirror stages,
// offset chain. Depends on mpsa_pkg, mpsa_cfg, mpsa_mirror and mpsa_offset.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One transfer in and one out per cycle unless the output stalls. The pipe holds
// two mirror stages and three offset multiply-add stages, one per inner dimension.
// Reset sets every dimension to extent 1 with no padding, reflect mode, empty pipe.
// A stall on the output backs up only through full stages; bubbles still fill,
// so o_in_stall rises only when all five stages hold an item.
// Configuration writes are taken every cycle; every stage reads the live setup,
// so writes belong between items, with the pipe empty.
`timescale 1ns / 1ps

module mirror_pad_source_address_unit
    import mpsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [SETUP_W-1:0] i_cfg_data
);

    t_cfg w_cfg;
    logic w_in_ready;
    logic w_mid_valid;
    logic w_mid_ready;
    t_mid w_mid;
    logic w_mir_full;
    logic w_off_full;

    // configuration registers
    mpsa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // per-dimension mirror
    mpsa_mirror u_mirror (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_in_valid),
        .o_ready (w_in_ready),
        .i_item  (i_in_data),
        .o_valid (w_mid_valid),
        .i_ready (w_mid_ready),
        .o_mid   (w_mid),
        .o_full  (w_mir_full)
    );

    // flat offset
    mpsa_offset u_offset (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_mid_valid),
        .o_ready (w_mid_ready),
        .i_mid   (w_mid),
        .o_valid (o_out_valid),
        .i_ready (!i_out_stall),
        .o_item  (o_out_data),
        .o_full  (w_off_full)
    );

    assign o_in_stall = !w_in_ready;

    // input stalls only with every stage full and the output blocked
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (w_mir_full && w_off_full && o_out_valid && i_out_stall))
        else $error("input stalled while the pipeline has a bubble");

endmodule

/* verif/mirror_pad_source_address_unit_tb.sv */
// Testbench for the mirror-pad source address unit: directed table, then random setups.
// Predicts each source address in-bench or takes it from the table, and checks each output transfer field by field.
// Depends on mpsa_pkg and mirror_pad_source_address_unit.
`timescale 1ns / 1ps

module mirror_pad_source_address_unit_tb;

    import mpsa_pkg::*;

    localparam int PIPE_LATENCY    = 5;
    localparam int QUIET_LIMIT     = 5000;
    localparam int HOLD_CYCLES     = 400;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int PRINT_CAP       = 100;
    localparam int COORD_MAX       = 2 ** COORD_W - 1;
    localparam int PAD_MAX         = 2 ** PAD_W - 1;

    typedef enum logic [1:0] {ROW_WRITE, ROW_ITEM, ROW_PINNED} t_row_kind;

    // one line of the directed table
    typedef struct packed {
        t_row_kind          kind;
        logic [IDX_W-1:0]   idx;
        logic [SETUP_W-1:0] value;
        t_in_item           coords;
        t_out_item          result;
    } t_script_row;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    t_in_item           i_in_data   = '0;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [IDX_W-1:0]   i_cfg_index = REG_DIM0;
    logic [SETUP_W-1:0] i_cfg_data  = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_cfg_ready;
    t_out_item          o_out_data;

    // expectation travelling with the offered item when the table fixes it
    logic      offer_pinned = 1'b0;
    t_out_item offer_result = '0;

    logic [SETUP_W-1:0] setup_shadow [NUM_DIMS];
    logic               mode_shadow;

    t_out_item     expected_addresses [$];
    t_out_item     next_address;
    t_script_row   script [$];
    int            items_sent         = 0;
    int            addresses_returned = 0;
    int            mismatches         = 0;
    int            quiet_cycles       = 0;
    int            hold_left          = 0;
    int            src_idle_pct       = 0;
    int            sink_stall_pct     = 0;

    mirror_pad_source_address_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // pack one dimension setup word
    function automatic logic [SETUP_W-1:0] dim_word(input int unsigned ext,
                                                    input int unsigned pre,
                                                    input int unsigned post);
        return {post[PAD_W-1:0], pre[PAD_W-1:0], ext[EXT_W-1:0]};
    endfunction

    function automatic t_in_item coords4(input int unsigned c0, input int unsigned c1,
                                         input int unsigned c2, input int unsigned c3);
        return '{COORD_W'(c0), COORD_W'(c1), COORD_W'(c2), COORD_W'(c3)};
    endfunction

    function automatic t_out_item result_of(input int unsigned s0, input int unsigned s1,
                                            input int unsigned s2, input int unsigned s3,
                                            input longint unsigned off,
                                            input bit rng, input bit pad);
        return '{SRC_W'(s0), SRC_W'(s1), SRC_W'(s2), SRC_W'(s3), OFF_W'(off), rng, pad};
    endfunction

    function automatic void row_write(input logic [IDX_W-1:0] idx,
                                      input logic [SETUP_W-1:0] value);
        script.push_back('{ROW_WRITE, idx, value, '0, '0});
    endfunction

    function automatic void row_item(input t_in_item c);
        script.push_back('{ROW_ITEM, REG_DIM0, '0, c, '0});
    endfunction

    function automatic void row_pinned(input t_in_item c, input t_out_item r);
        script.push_back('{ROW_PINNED, REG_DIM0, '0, c, r});
    endfunction

    // mirrored source coordinates and flat offset under the current setup
    function automatic t_out_item mirror_source(input t_in_item item);
        t_out_item          res;
        logic [COORD_W-1:0] pos [NUM_DIMS];
        logic [SRC_W-1:0]   src [NUM_DIMS];
        longint             ext, pre, post, crd, j, s, sym, flat;
        bit                 range_hit, pad_hit;
        pos[0]    = item.out_coord0;
        pos[1]    = item.out_coord1;
        pos[2]    = item.out_coord2;
        pos[3]    = item.out_coord3;
        flat      = 0;
        range_hit = 1'b0;
        pad_hit   = 1'b0;
        sym       = (mode_shadow == SYMMETRIC) ? 1 : 0;
        for (int d = 0; d < NUM_DIMS; d++) begin
            // dimensions above the rank act as extent 1 at coordinate 0
            if (d >= FIRST_ACTIVE) begin
                ext  = longint'(setup_shadow[d][EXT_W-1:0]);
                pre  = longint'(setup_shadow[d][EXT_W +: PAD_W]);
                post = longint'(setup_shadow[d][EXT_W+PAD_W +: PAD_W]);
                crd  = longint'(pos[d]);
                if (ext == 0) ext = 1;
                if (ext > MAX_EXTENT) ext = MAX_EXTENT;
            end else begin
                ext  = 1;
                pre  = 0;
                post = 0;
                crd  = 0;
            end
            if (pre > ext - 1 + sym || post > ext - 1 + sym) pad_hit = 1'b1;
            if (crd >= ext + pre + post) range_hit = 1'b1;
            // fold around the edges, then clamp into the tensor
            j = crd - pre;
            if (j < 0) s = -j - sym;
            else if (j >= ext) s = 2 * ext - 2 + sym - j;
            else s = j;
            if (s < 0) s = 0;
            if (s > ext - 1) s = ext - 1;
            flat   = flat * ext + s;
            src[d] = s[SRC_W-1:0];
        end
        res.src_coord0    = src[0];
        res.src_coord1    = src[1];
        res.src_coord2    = src[2];
        res.src_coord3    = src[3];
        res.source_offset = flat[OFF_W-1:0];
        res.range_error   = range_hit;
        res.pad_error     = pad_hit;
        return res;
    endfunction

    // mostly small extents with legal padding, some zero, oversized or excess pads
    function automatic logic [SETUP_W-1:0] random_dim_word();
        int unsigned ext, eff, roll;
        int unsigned pads [2];
        roll = $urandom_range(0, 99);
        if (roll < 60) ext = $urandom_range(1, 12);
        else if (roll < 70) ext = 0;
        else if (roll < 80) ext = $urandom_range(MAX_EXTENT + 1, 2 ** EXT_W - 1);
        else ext = $urandom_range(1, MAX_EXTENT);
        eff = (ext == 0) ? 1 : (ext > MAX_EXTENT) ? MAX_EXTENT : ext;
        for (int k = 0; k < 2; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) pads[k] = $urandom_range(0, eff - 1);
            else if (roll < 92) pads[k] = (eff > PAD_MAX) ? PAD_MAX : eff;
            else pads[k] = $urandom_range(0, PAD_MAX);
        end
        return dim_word(ext, pads[0], pads[1]);
    endfunction

    // coordinates mostly inside the padded extent, some on its borders, some anywhere
    function automatic t_in_item random_coords();
        logic [COORD_W-1:0] pos [NUM_DIMS];
        int unsigned        ext, pre, post, span, roll;
        for (int d = 0; d < NUM_DIMS; d++) begin
            ext  = setup_shadow[d][EXT_W-1:0];
            pre  = setup_shadow[d][EXT_W +: PAD_W];
            post = setup_shadow[d][EXT_W+PAD_W +: PAD_W];
            if (ext == 0) ext = 1;
            if (ext > MAX_EXTENT) ext = MAX_EXTENT;
            span = ext + pre + post;
            roll = $urandom_range(0, 99);
            if (roll < 85) begin
                pos[d] = COORD_W'($urandom_range(0, span - 1));
            end else if (roll < 93) begin
                case ($urandom_range(0, 3))
                    0:       pos[d] = COORD_W'(pre);
                    1:       pos[d] = COORD_W'(pre + ext - 1);
                    2:       pos[d] = COORD_W'(span - 1);
                    default: pos[d] = COORD_W'(span);
                endcase
            end else begin
                pos[d] = COORD_W'($urandom_range(0, COORD_MAX));
            end
        end
        return '{pos[0], pos[1], pos[2], pos[3]};
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatches < PRINT_CAP)
            $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // offer one item, with optional idle gaps first, until it transfers
    task automatic send_item(input t_in_item item, input bit pinned, input t_out_item result);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_in_data    <= item;
        offer_pinned <= pinned;
        offer_result <= result;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // register write; valid stays high so writes can go back to back
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SETUP_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_MODE) mode_shadow = value[0];
        else if (idx < REG_MODE) setup_shadow[idx] = value;
    endtask

    // stop offering, wait for every address to come back, then let the pipe empty
    task automatic drain();
        i_in_valid  <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (addresses_returned != items_sent) @(posedge i_clk);
        repeat (PIPE_LATENCY) @(posedge i_clk);
    endtask

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
        end
    end

    // scoreboard: check output transfers, then record input transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_addresses.size() == 0) begin
                    report_mismatch("unexpected output transfer", o_out_data.source_offset, 0);
                end else begin
                    next_address = expected_addresses.pop_front();
                    if (o_out_data.src_coord0 !== next_address.src_coord0)
                        report_mismatch("src_coord0", o_out_data.src_coord0,
                                        next_address.src_coord0);
                    if (o_out_data.src_coord1 !== next_address.src_coord1)
                        report_mismatch("src_coord1", o_out_data.src_coord1,
                                        next_address.src_coord1);
                    if (o_out_data.src_coord2 !== next_address.src_coord2)
                        report_mismatch("src_coord2", o_out_data.src_coord2,
                                        next_address.src_coord2);
                    if (o_out_data.src_coord3 !== next_address.src_coord3)
                        report_mismatch("src_coord3", o_out_data.src_coord3,
                                        next_address.src_coord3);
                    if (o_out_data.source_offset !== next_address.source_offset)
                        report_mismatch("source_offset", o_out_data.source_offset,
                                        next_address.source_offset);
                    if (o_out_data.range_error !== next_address.range_error)
                        report_mismatch("range_error", o_out_data.range_error,
                                        next_address.range_error);
                    if (o_out_data.pad_error !== next_address.pad_error)
                        report_mismatch("pad_error", o_out_data.pad_error,
                                        next_address.pad_error);
                    addresses_returned <= addresses_returned + 1;
                end
            end
            if (i_in_valid && !o_in_stall)
                expected_addresses.push_back(offer_pinned ? offer_result
                                                          : mirror_source(i_in_data));
        end
    end

    // watchdog on cycles without any transfer; stray output transfers do not count
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall && expected_addresses.size() != 0) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial begin
        for (int d = 0; d < NUM_DIMS; d++) setup_shadow[d] = SETUP_RESET;
        mode_shadow = REFLECT;

        // reset setup: extent 1 everywhere, anything but the origin is out of range
        row_pinned(coords4(0, 0, 0, 0), result_of(0, 0, 0, 0, 0, 0, 0));
        row_pinned(coords4(0, 0, 0, 1), result_of(0, 0, 0, 0, 0, 1, 0));
        row_pinned(coords4(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX),
                   result_of(0, 0, 0, 0, 0, 1, 0));
        // reflect on a small inner dimension
        row_write(REG_DIM3, dim_word(5, 2, 2));
        row_pinned(coords4(0, 0, 0, 0), result_of(0, 0, 0, 2, 2, 0, 0));
        row_item(coords4(0, 0, 0, 4));
        row_item(coords4(0, 0, 0, 8));
        row_item(coords4(0, 0, 0, 9));
        // symmetric keeps the edge
        row_write(REG_MODE, SETUP_W'(SYMMETRIC));
        row_pinned(coords4(0, 0, 0, 0), result_of(0, 0, 0, 1, 1, 0, 0));
        row_item(coords4(0, 0, 0, 8));
        // pre pad too large: clamped source, and both flags together
        row_write(REG_DIM3, dim_word(5, 6, 0));
        row_item(coords4(0, 0, 0, 0));
        row_item(coords4(0, 0, 0, 20));
        // zero extent reads as 1, oversized extent saturates
        row_write(REG_DIM3, dim_word(0, 0, 0));
        row_write(REG_DIM2, dim_word(2 ** EXT_W - 1, 0, 0));
        row_write(REG_MODE, SETUP_W'(REFLECT));
        row_item(coords4(0, 0, MAX_EXTENT - 1, 0));
        row_item(coords4(0, 0, 5000, 0));
        // largest tensor, far corner gives the top offset
        row_write(REG_DIM0, dim_word(MAX_EXTENT, 0, 0));
        row_write(REG_DIM1, dim_word(MAX_EXTENT, 0, 0));
        row_write(REG_DIM2, dim_word(MAX_EXTENT, 0, 0));
        row_write(REG_DIM3, dim_word(MAX_EXTENT, 0, 0));
        row_pinned(coords4(4095, 4095, 4095, 4095),
                   result_of(4095, 4095, 4095, 4095, 48'hFFFF_FFFF_FFFF, 0, 0));
        row_pinned(coords4(0, 0, 0, 0), result_of(0, 0, 0, 0, 0, 0, 0));
        // largest legal pads on every dimension
        row_write(REG_DIM0, dim_word(MAX_EXTENT, PAD_MAX, PAD_MAX));
        row_write(REG_DIM1, dim_word(MAX_EXTENT, PAD_MAX, PAD_MAX));
        row_write(REG_DIM2, dim_word(MAX_EXTENT, PAD_MAX, PAD_MAX));
        row_write(REG_DIM3, dim_word(MAX_EXTENT, PAD_MAX, PAD_MAX));
        row_item(coords4(0, 0, 0, 0));
        row_item(coords4(12285, 12285, 12285, 12285));
        row_item(coords4(12286, 0, 0, 0));
        row_item(coords4(12287, 12287, 12287, 12287));
        row_write(REG_MODE, SETUP_W'(SYMMETRIC));
        row_item(coords4(0, 0, 0, 0));
        row_item(coords4(12285, 12285, 12285, 12285));
        // write to an unused index must change nothing
        row_write(IDX_W'(REG_MODE + 3), {SETUP_W{1'b1}});
        row_item(coords4(100, 200, 300, 400));
        // pad of one on extent 1 is legal only in symmetric mode
        row_write(REG_DIM1, dim_word(1, 1, 0));
        row_item(coords4(0, 0, 0, 0));
        row_write(REG_MODE, SETUP_W'(REFLECT));
        row_item(coords4(0, 0, 0, 0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (script[k]) begin
            if (script[k].kind == ROW_WRITE) begin
                drain();
                write_reg(script[k].idx, script[k].value);
            end else begin
                i_cfg_valid <= 1'b0;
                send_item(script[k].coords, script[k].kind == ROW_PINNED, script[k].result);
            end
        end

        // random setups, each phase with one of four idling profiles
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            logic [SETUP_W-1:0] mode_word;
            drain();
            write_reg(REG_DIM0, random_dim_word());
            write_reg(REG_DIM1, random_dim_word());
            write_reg(REG_DIM2, random_dim_word());
            write_reg(REG_DIM3, random_dim_word());
            mode_word    = SETUP_W'({$urandom, $urandom});
            mode_word[0] = ($urandom_range(0, 1) == 1) ? SYMMETRIC : REFLECT;
            write_reg(REG_MODE, mode_word);
            if ($urandom_range(0, 1) == 1)
                write_reg(IDX_W'(REG_MODE + 1 + $urandom_range(0, 2)),
                          SETUP_W'({$urandom, $urandom}));
            i_cfg_valid <= 1'b0;
            case (phase % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 77; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 77; end
                default: begin src_idle_pct = 24; sink_stall_pct = 24; end
            endcase
            // long receiver hold-off while items keep coming, to back up the pipe
            if (phase == 2) hold_left = HOLD_CYCLES;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == 60 || $urandom_range(0, 199) == 0) drain();
                send_item(random_coords(), 1'b0, '0);
            end
        end

        drain();
        repeat (4 * PIPE_LATENCY) @(posedge i_clk);
        if (expected_addresses.size() != 0)
            report_mismatch("addresses never returned", expected_addresses.size(), 0);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
src/mpsa_pkg.sv
src/mpsa_cfg.sv
src/mpsa_mirror.sv
src/mpsa_offset.sv
src/mirror_pad_source_address_unit.sv
verif/mirror_pad_source_address_unit_tb.sv
